/* sv/tlg_pkg.sv */
// shared constants for the toroidal life generation block
`default_nettype none

package tlg_pkg;

   // board size defaults
   localparam int ROWS_DEFAULT = 32;
   localparam int COLS_DEFAULT = 32;

   // field widths
   localparam int OP_W    = 2;
   localparam int IDX_W   = 5;
   localparam int BITS_W  = 32;
   localparam int TDATA_W = 40;

   // operation codes
   localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
   localparam logic [OP_W-1:0] OP_STEP  = 2'd1;
   localparam logic [OP_W-1:0] OP_READ  = 2'd2;

endpackage

`default_nettype wire

/* sv/toroidal_life_generation.sv */
// toroidal life board, rule b3/s23, with row write, row read and generation step
//
// req channel: one transfer carries one operation (tuser) with a row index and a
// row word (tdata). write row stores the word, step advances the whole board by one
// generation on a torus, read row returns one row word. every transfer on req gives
// exactly one transfer on rsp, which echoes the operation in tuser and carries the
// row index (reads only) and the row cells (reads only) in tdata.
// the board lives in a row memory with a write port and a registered read port; one
// row of life logic, shared by every row, computes a whole new row per cycle while a
// small sequencer walks the rows with a three-row window (old row above, current row,
// and the row below, which at the bottom is the saved old row 0 for the wrap).
// a write or unused code goes from idle through S_DONE into the rsp register; a read
// goes through S_READ and S_DONE; a step goes through S_STEP_FIRST, S_STEP_LOAD, one
// S_STEP_RUN pass per row (one memory read per row) and S_DONE, then back to S_IDLE.
// one operation is in flight at a time; req_tready is high only when the sequencer
// is idle. a finished result sits in the rsp register while the next req is taken;
// if rsp_tready is low the next result waits in its own holding register.
// reset clears the board to dead through per-row valid bits, so no clearing pass
// is needed, and empties the rsp register.
`default_nettype none

module toroidal_life_generation
   import tlg_pkg::*;
#(
   parameter int ROWS = ROWS_DEFAULT,
   parameter int COLS = COLS_DEFAULT
) (
   input  wire                 clock,
   input  wire                 reset,
   // request channel
   input  wire                 req_tvalid,
   output logic                req_tready,
   input  wire [TDATA_W-1:0]   req_tdata,   // row_index[4:0], row_bits[36:5], zero fill
   input  wire [OP_W-1:0]      req_tuser,   // operation[1:0]
   // response channel
   output logic                rsp_tvalid,
   input  wire                 rsp_tready,
   output logic [TDATA_W-1:0]  rsp_tdata,   // result_row[4:0], read_bits[36:5], zero fill
   output logic [OP_W-1:0]     rsp_tuser    // done_operation[1:0]
);

   localparam int ROW_W = $clog2(ROWS);

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_STEP_FIRST,
      S_STEP_LOAD,
      S_STEP_RUN,
      S_DONE
   } state_type;

   state_type state_ff, state_in;

   // row memory and its valid bits
   logic [COLS-1:0]  mem [ROWS];
   logic [ROWS-1:0]  valid_ff;
   logic [COLS-1:0]  mem_q_ff;
   logic             mem_q_valid_ff;
   logic [COLS-1:0]  rdata;

   logic             mem_we;
   logic [ROW_W-1:0] mem_wa;
   logic [COLS-1:0]  mem_wd;
   logic [ROW_W-1:0] rd_addr_in;

   // step window
   logic [COLS-1:0]  prev_ff, prev_in;
   logic [COLS-1:0]  cur_ff, cur_in;
   logic [COLS-1:0]  first_ff, first_in;
   logic [ROW_W-1:0] step_row_ff, step_row_in;
   logic [COLS-1:0]  down_row;
   logic [COLS-1:0]  next_row;

   // pending result and output register
   logic [OP_W-1:0]    res_tuser_ff, res_tuser_in;
   logic [TDATA_W-1:0] res_tdata_ff, res_tdata_in;
   logic               rsp_tvalid_ff, rsp_tvalid_in;
   logic [OP_W-1:0]    rsp_tuser_ff, rsp_tuser_in;
   logic [TDATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   // request fields
   logic [IDX_W-1:0]  req_idx;
   logic [BITS_W-1:0] req_bits;
   logic              req_in_range;
   logic              req_fire;

   logic [ROW_W:0]    ahead_row;
   logic [63:0]       rdata_wide;
   logic [63:0]       req_bits_wide;

   assign req_idx      = req_tdata[IDX_W-1:0];
   assign req_bits     = req_tdata[IDX_W+BITS_W-1:IDX_W];
   assign req_in_range = ({1'b0, req_idx} < (IDX_W+1)'(ROWS));
   assign req_tready   = (state_ff == S_IDLE);
   assign req_fire     = req_tvalid && req_tready;

   assign rdata         = mem_q_valid_ff ? mem_q_ff : '0;
   assign rdata_wide    = 64'(rdata);
   assign req_bits_wide = 64'(req_bits);
   assign ahead_row     = {1'b0, step_row_ff} + (ROW_W+1)'(2);

   // last row wraps down onto the saved old row 0
   assign down_row = (step_row_ff == ROW_W'(ROWS-1)) ? first_ff : rdata;

   // one row of life cells with wrap at the side edges
   for (genvar c = 0; c < COLS; c++) begin : g_cell
      localparam int CL = (c == 0) ? COLS-1 : c-1;
      localparam int CR = (c == COLS-1) ? 0 : c+1;
      logic [3:0] count;
      assign count = 4'(prev_ff[CL]) + 4'(prev_ff[c]) + 4'(prev_ff[CR])
                   + 4'(cur_ff[CL]) + 4'(cur_ff[CR])
                   + 4'(down_row[CL]) + 4'(down_row[c]) + 4'(down_row[CR]);
      assign next_row[c] = (count == 4'd3) || ((count == 4'd2) && cur_ff[c]);
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      prev_in       = prev_ff;
      cur_in        = cur_ff;
      first_in      = first_ff;
      step_row_in   = step_row_ff;
      res_tuser_in  = res_tuser_ff;
      res_tdata_in  = res_tdata_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      mem_we        = 1'b0;
      mem_wa        = '0;
      mem_wd        = '0;
      rd_addr_in    = '0;

      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               res_tuser_in = req_tuser;
               res_tdata_in = '0;
               case (req_tuser)
                  OP_WRITE: begin
                     mem_we   = req_in_range;
                     mem_wa   = req_idx[ROW_W-1:0];
                     mem_wd   = req_bits_wide[COLS-1:0];
                     state_in = S_DONE;
                  end
                  OP_STEP: begin
                     rd_addr_in = ROW_W'(ROWS-1);
                     state_in   = S_STEP_FIRST;
                  end
                  OP_READ: begin
                     rd_addr_in = req_in_range ? req_idx[ROW_W-1:0] : '0;
                     res_tdata_in[IDX_W-1:0] = req_idx;
                     // out-of-range reads give zero cells
                     res_tdata_in[TDATA_W-1] = !req_in_range;
                     state_in   = S_READ;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_READ: begin
            res_tdata_in[IDX_W+BITS_W-1:IDX_W] =
               res_tdata_ff[TDATA_W-1] ? '0 : rdata_wide[BITS_W-1:0];
            res_tdata_in[TDATA_W-1] = 1'b0;
            state_in = S_DONE;
         end
         S_STEP_FIRST: begin
            // old last row is the row above row 0
            prev_in    = rdata;
            rd_addr_in = '0;
            state_in   = S_STEP_LOAD;
         end
         S_STEP_LOAD: begin
            cur_in      = rdata;
            first_in    = rdata;
            rd_addr_in  = ROW_W'(1);
            step_row_in = '0;
            state_in    = S_STEP_RUN;
         end
         S_STEP_RUN: begin
            mem_we  = 1'b1;
            mem_wa  = step_row_ff;
            mem_wd  = next_row;
            prev_in = cur_ff;
            cur_in  = down_row;
            if (ahead_row < (ROW_W+1)'(ROWS)) begin
               rd_addr_in = ahead_row[ROW_W-1:0];
            end
            if (step_row_ff == ROW_W'(ROWS-1)) begin
               state_in = S_DONE;
            end else begin
               step_row_in = step_row_ff + ROW_W'(1);
            end
         end
         S_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tuser_in  = res_tuser_ff;
               rsp_tdata_in  = res_tdata_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state, window and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_tvalid_ff <= 1'b0;
         valid_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (mem_we) begin
            valid_ff[mem_wa] <= 1'b1;
         end
      end
      prev_ff      <= prev_in;
      cur_ff       <= cur_in;
      first_ff     <= first_in;
      step_row_ff  <= step_row_in;
      res_tuser_ff <= res_tuser_in;
      res_tdata_ff <= res_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   // row memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      mem_q_ff       <= mem[rd_addr_in];
      mem_q_valid_ff <= valid_ff[rd_addr_in];
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

`default_nettype wire
